FILE: sv/sha256_byte_stream_hasher_macros.svh
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// Implication checked every clock outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

FILE: sv/sha_pkg.sv
// Package: payload types, constants and round functions for the SHA-256 hasher.
package sha_pkg;
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FINISH = 1'b1;
	localparam logic [7:0] PAD_MARKER = 8'h80;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word_0;
		logic [63:0] digest_word_1;
		logic [63:0] digest_word_2;
		logic [63:0] digest_word_3;
	} out_item_t;

	typedef logic [7:0][31:0] hash_t;

	localparam hash_t INIT_H = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			unique case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				6'd63: k = 32'hc67178f2;
				default: k = 32'h0;
			endcase
			return k;
		end
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction
endpackage

FILE: sv/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: one item appends a byte or finishes the message
// and returns the 256-bit digest. Appended bytes are written into a 64-entry
// byte RAM; an append only writes its byte unless it fills the block, when the
// block is read back (one byte per cycle plus the read latency, words packed
// into the schedule window) and compressed at one round per cycle (64 rounds,
// then a completion report). A finish writes the marker, then the padding
// bytes into the RAM one per cycle up to byte 63, runs one compression, or
// two when the tail is past byte 55, and then registers the digest; the
// engine then returns to the initial values.
// No input item is taken while padding, reading, compressing or while a new
// digest waits for the output register; a digest already held at the output
// does not block appends of the next message.
`include "sha256_byte_stream_hasher_macros.svh"
module sha256_byte_stream_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1; // writing padding bytes
	localparam logic [2:0] ST_READ = 3'd2; // reading block into schedule window
	localparam logic [2:0] ST_RUN  = 3'd3; // compression rounds
	localparam logic [2:0] ST_OUT  = 3'd4; // digest waiting for output slot

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic        fin_q;     // current message is being finished
	logic        last_q;    // block in flight carries the length
	logic [6:0]  rd_q;      // read pointer, counts 0..64 incl. latency
	logic [23:0] wacc_q;
	logic        ov_q;
	out_item_t   out_q;

	logic        we;
	logic [5:0]  waddr, raddr;
	logic [7:0]  wdata, rdata;
	logic        core_load, core_start, core_init, core_busy, core_done;
	hash_t       hash;
	logic        acc;
	logic [63:0] bitlen;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign bitlen = {len_q, 3'b000};

	always_comb begin
		we = 1'b0;
		waddr = fill_q;
		wdata = in_data.data_byte;
		if (acc) begin
			we = 1'b1;
			wdata = (in_data.command == CMD_APPEND) ? in_data.data_byte : PAD_MARKER;
		end else if (state_q == ST_PAD) begin
			we = 1'b1;
			if (fill_q >= 6'd56 && last_q) begin
				// length bytes, most significant first
				wdata = bitlen[{~fill_q[2:0], 3'b111} -: 8];
			end else begin
				wdata = 8'h00;
			end
		end
	end

	assign raddr = rd_q[5:0];

	sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign core_load = (state_q == ST_READ) && (rd_q != 7'd0) && (rd_q[1:0] == 2'b00);
	assign core_start = (state_q == ST_READ) && (rd_q == 7'd64);
	assign core_init = (state_q == ST_OUT) && !ov_q;

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .load(core_load),
		.load_word({wacc_q, rdata}), .start(core_start), .init(core_init),
		.busy(core_busy), .done(core_done), .hash(hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			len_q <= '0;
			fin_q <= 1'b0;
			last_q <= 1'b0;
			rd_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fill_q <= fill_q + 6'd1;
						rd_q <= '0;
						if (in_data.command == CMD_APPEND) begin
							len_q <= len_q + 61'd1;
							if (fill_q == 6'd63) begin
								state_q <= ST_READ;
							end
						end else begin
							fin_q <= 1'b1;
							last_q <= (fill_q < 6'd56);
							state_q <= (fill_q == 6'd63) ? ST_READ : ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						rd_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rd_q <= rd_q + 7'd1;
					if (rd_q == 7'd64) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (core_done) begin
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (!last_q) begin
							last_q <= 1'b1;
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
						fin_q <= 1'b0;
						last_q <= 1'b0;
						len_q <= '0;
						fill_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			wacc_q <= {wacc_q[15:0], rdata};
		end
		if (state_q == ST_OUT && !ov_q) begin
			out_q <= {hash[0], hash[1], hash[2], hash[3], hash[4], hash[5], hash[6], hash[7]};
		end
	end

	assign out_valid = ov_q;
	assign out_data = out_q;

	`SHA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, core_busy, !acc)
	`SHA_ASSERT_NXT(a_out_hold, clk, arst_n, ov_q && out_stall, ov_q && $stable(out_q))
	`SHA_ASSERT_IMP(a_done_in_run, clk, arst_n, core_done, state_q == ST_RUN)
endmodule

FILE: sv/sha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/sha_core.sv
// SHA-256 compression engine: 16-word schedule window and one round per cycle.
module sha_core import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,       // word of the block arrives (16 of them)
	input  logic [31:0] load_word,
	input  logic        start,      // all 16 words loaded, run the rounds
	input  logic        init,       // return chaining words to initial values
	output logic        busy,
	output logic        done,       // one-cycle pulse, chaining words updated
	output hash_t       hash
);
	logic [15:0][31:0] w_q;
	logic [7:0][31:0]  v_q;
	hash_t             h_q;
	logic [5:0]        rnd_q;
	logic              run_q;
	logic              done_q;

	logic [31:0] s0, s1, w_new, t1, t2, ch, maj, e, a;
	logic [7:0][31:0] v_nxt;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		e = v_q[4];
		a = v_q[0];
		ch = (e & v_q[5]) ^ (~e & v_q[6]);
		maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + round_k(rnd_q) + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
		v_nxt = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= INIT_H;
			rnd_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (init) begin
				h_q <= INIT_H;
			end
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_nxt[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			w_q <= {load_word, w_q[15:1]};
		end else if (run_q) begin
			w_q <= {w_new, w_q[15:1]};
		end
		if (start) begin
			v_q <= h_q;
		end else if (run_q) begin
			v_q <= v_nxt;
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign hash = h_q;
endmodule

FILE: dv/sha256_byte_stream_hasher_tb.sv
// Testbench for the SHA-256 byte stream hasher, checked against a local digest model.
module sha256_byte_stream_hasher_tb import sha_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	sha256_byte_stream_hasher uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Local digest model state
	hash_t       chain_h;
	logic [7:0]  blk_bytes [64];
	int unsigned blk_fill;
	logic [60:0] msg_len;

	out_item_t digest_q [$];
	int        fail_count;
	bit        sender_bursty;   // random gaps between items when set
	bit        rx_random;       // random stall pattern on the result side
	bit        hold_go;         // start the long result-side hold-off
	int        hold_cnt = 0;    // cycles of hold-off so far

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// SHA-256 round constants.
	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror32(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// One 64-round compression of blk_bytes into chain_h.
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		{h, g, f, e, d, c, b, a} = chain_h;
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endtask

	function automatic void digest_reset();
		chain_h  = INIT_H;
		blk_fill = 0;
		msg_len  = '0;
	endfunction

	// Advance the digest model by one accepted item; a finish queues a digest.
	task automatic digest_step(in_item_t it);
		logic [63:0] bits;
		out_item_t   d;
		if (it.command == CMD_APPEND) begin
			blk_bytes[blk_fill] = it.data_byte;
			blk_fill++;
			msg_len++;
			if (blk_fill == 64) begin
				compress_block();
				blk_fill = 0;
			end
		end else begin
			bits = {msg_len, 3'b000};
			blk_bytes[blk_fill] = PAD_MARKER;
			blk_fill++;
			// tail past byte 55: length spills into a second block
			if (blk_fill > 56) begin
				for (int i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
				compress_block();
				blk_fill = 0;
			end
			for (int i = blk_fill; i < 56; i++) blk_bytes[i] = 8'h00;
			for (int i = 0; i < 8; i++) blk_bytes[56+i] = bits[63-8*i -: 8];
			compress_block();
			d.digest_word_0 = {chain_h[0], chain_h[1]};
			d.digest_word_1 = {chain_h[2], chain_h[3]};
			d.digest_word_2 = {chain_h[4], chain_h[5]};
			d.digest_word_3 = {chain_h[6], chain_h[7]};
			digest_q.insert(digest_q.size(), d);
			digest_reset();
		end
	endtask

	// Offer one item; hold it until accepted, then update the model.
	// Valid stays high into the next call unless a gap is taken.
	task automatic send_item(logic cmd, logic [7:0] byte_val);
		in_item_t it;
		if (sender_bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		it.command   = cmd;
		it.data_byte = byte_val;
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		digest_step(it);
		@(negedge clk);
	endtask

	task automatic send_message(int n, bit random_fill, logic [7:0] fill);
		for (int i = 0; i < n; i++)
			send_item(CMD_APPEND, random_fill ? 8'($urandom_range(0, 255)) : fill);
		send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Result-side stall pattern and long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_go && hold_cnt < 2000) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
		end else if (rx_random) begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t exp_d;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest %h", out_data);
				fail_count++;
			end else begin
				exp_d = digest_q.pop_front();
				if (out_data.digest_word_0 !== exp_d.digest_word_0) begin
					$error("digest_word_0 exp %h got %h", exp_d.digest_word_0, out_data.digest_word_0);
					fail_count++;
				end
				if (out_data.digest_word_1 !== exp_d.digest_word_1) begin
					$error("digest_word_1 exp %h got %h", exp_d.digest_word_1, out_data.digest_word_1);
					fail_count++;
				end
				if (out_data.digest_word_2 !== exp_d.digest_word_2) begin
					$error("digest_word_2 exp %h got %h", exp_d.digest_word_2, out_data.digest_word_2);
					fail_count++;
				end
				if (out_data.digest_word_3 !== exp_d.digest_word_3) begin
					$error("digest_word_3 exp %h got %h", exp_d.digest_word_3, out_data.digest_word_3);
					fail_count++;
				end
			end
		end
	end

	// Empty message, single bytes at both extremes, a 3-byte message, tails at 55/56/63/64/65 bytes.
	task automatic test_boundaries();
		send_item(CMD_FINISH, 8'h00);
		send_item(CMD_FINISH, 8'hff);
		send_message(1, 0, 8'h00);
		send_message(1, 0, 8'hff);
		send_message(3, 0, 8'h61);
		send_message(55, 0, 8'hff);
		send_message(56, 0, 8'h00);
		send_message(63, 1, 8'h00);
		send_message(64, 1, 8'h00);
		send_message(65, 1, 8'h00);
	endtask

	// Well-formed messages of random length and content, with gaps and stalls.
	task automatic test_random_messages();
		int n;
		sender_bursty = 1'b1;
		rx_random     = 1'b1;
		for (int m = 0; m < 22; m++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 12);
			send_message(n, 1, 8'h00);
		end
	endtask

	// Hold results off long enough for finishes to back up into the input.
	task automatic test_backpressure();
		sender_bursty = 1'b0;
		hold_go       = 1'b1;
		for (int m = 0; m < 6; m++) send_message($urandom_range(0, 5), 1, 8'h00);
		rx_random = 1'b0;
	endtask

	initial begin
		fail_count    = 0;
		sender_bursty = 1'b0;
		rx_random     = 1'b0;
		hold_go       = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		arst_n        = 1'b0;
		digest_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_boundaries();
		test_random_messages();
		test_backpressure();
		in_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+sv
sv/sha_pkg.sv
sv/sha_ram.sv
sv/sha_core.sv
sv/sha256_byte_stream_hasher.sv
dv/sha256_byte_stream_hasher_tb.sv
